### rtl/fosu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fosu_pkg: shared types, constants and twiddle functions
// Holds the quarter-wave sine table, the twiddle lookups and the command and
// status structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fosu_pkg;

   localparam int SampleWidth = 16;
   localparam int OutWidth    = 18;
   localparam int SpecWidth   = 40;
   localparam int AccWidth    = 64;
   localparam int ProdWidth   = SpecWidth + SampleWidth;

   localparam logic [7:0] NewLast   = 8'd191;
   localparam logic [7:0] KeepLen   = 8'd64;
   localparam logic [7:0] AdvanceBy = 8'd192;
   localparam logic [7:0] LowLast   = 8'd127;
   localparam logic [7:0] HighFirst = 8'd129;
   localparam logic [7:0] BinLast   = 8'd255;
   localparam logic [8:0] FirstOut  = 9'd64;
   localparam logic [8:0] LastOut   = 9'd447;
   localparam logic [2:0] SlotLast  = 3'd7;

   typedef logic signed [15:0] twid_type;
   typedef twid_type qsin_type [0:128];

   function automatic qsin_type build_qsin();
      qsin_type    tab;
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] val;
      for (int t = 0; t <= 128; t++) begin
         a    = (64'(t) * 64'd1686629713) / 64'd128;
         a2   = (a * a) >> 30;
         term = a;
         pos  = a;
         neg  = 64'd0;
         for (int n = 1; n <= 8; n++) begin
            term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
               neg = neg + term;
            end else begin
               pos = pos + term;
            end
         end
         val = (pos > neg) ? pos - neg : 64'd0;
         val = (val + 64'd16384) >> 15;
         if (val > 64'd32767) begin
            val = 64'd32767;
         end
         tab[t] = twid_type'(val[15:0]);
      end
      return tab;
   endfunction

   localparam qsin_type QSin = build_qsin();

   function automatic twid_type sin_lookup(input logic [8:0] idx);
      logic [7:0] ri;
      twid_type   mag;
      ri = idx[7] ? (8'd128 - {1'b0, idx[6:0]}) : {1'b0, idx[6:0]};
      mag = QSin[ri];
      return idx[8] ? -mag : mag;
   endfunction

   function automatic twid_type cos_lookup(input logic [8:0] idx);
      return sin_lookup(idx + 9'd128);
   endfunction

   typedef struct packed {
      logic       issue;
      logic       first;
      logic       last;
      logic       inv;
      logic [7:0] addr;
      logic [8:0] twid;
      logic       smp_we;
      logic [7:0] fill;
      logic [7:0] wr_k;
      logic       load_rsp;
      logic       rsp_last;
      logic       advance;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

### rtl/fosu_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fosu_datapath: window store, spectrum store, MAC pipeline and output words
// A multiply-accumulate pipeline serves both the forward and the
// inverse transform; finished bins and samples are rounded and stored.
// ----------------------------------------------------------------------------
module fosu_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic signed [15:0]     req_sample,
   input  wire fosu_pkg::cmd_type      cmd,
   output fosu_pkg::status_type        status,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   output logic signed [17:0]          rsp_out_a,
   output logic signed [17:0]          rsp_out_b,
   output logic signed [17:0]          rsp_out_c,
   output logic signed [17:0]          rsp_out_d,
   output logic signed [17:0]          rsp_out_e,
   output logic signed [17:0]          rsp_out_f,
   output logic signed [17:0]          rsp_out_g,
   output logic signed [17:0]          rsp_out_h,
   output logic                        rsp_last_of_block
);
   import fosu_pkg::*;

   localparam logic signed [63:0] RndFwd  = 64'sd16384;
   localparam logic signed [63:0] RndInv  = 64'sd4194304;
   localparam logic signed [63:0] AccLim  = 64'sd4611686018427387904;
   localparam logic signed [63:0] SpecMax = 64'sd549755813887;
   localparam logic signed [63:0] SpecMin = -64'sd549755813888;
   localparam logic signed [63:0] OutMax  = 64'sd131071;
   localparam logic signed [63:0] OutMin  = -64'sd131072;

   logic signed [SampleWidth-1:0] smp_mem [0:255];
   logic signed [SpecWidth-1:0]   spec_re_mem [0:255];
   logic signed [SpecWidth-1:0]   spec_im_mem [0:255];

   logic [7:0] base_ff, base_in;
   logic       first_block_ff, first_block_in;
   logic [7:0] rd_addr;
   logic [7:0] wr_addr;

   logic                          valid_s1_ff, first_s1_ff, last_s1_ff, inv_s1_ff, zero_s1_ff;
   logic [8:0]                    twid_s1_ff;
   logic signed [SampleWidth-1:0] smp_rd_ff;
   logic signed [SpecWidth-1:0]   re_rd_ff, im_rd_ff;

   logic                        valid_s2_ff, first_s2_ff, last_s2_ff, inv_s2_ff;
   logic signed [ProdWidth-1:0] pc_ff, ps_ff;
   logic signed [SpecWidth-1:0] op_c, op_s;
   twid_type                    cos_v, sin_v;

   logic                       done_ff, inv_s3_ff;
   logic signed [AccWidth-1:0] acc_a_ff, acc_b_ff, acc_a_in, acc_b_in;
   logic signed [AccWidth-1:0] pc_x, ps_x;

   logic signed [AccWidth-1:0]  fr_s, fi_s, inv_v, inv_w;
   logic signed [SpecWidth-1:0] fr_sat, fi_sat;
   logic signed [OutWidth-1:0]  out_sat;

   logic signed [OutWidth-1:0] slot_ff [0:7];
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [OutWidth-1:0] rsp_ff [0:7];
   logic                       rsp_last_ff;

   assign rd_addr = base_ff + cmd.addr;
   assign wr_addr = base_ff + KeepLen + cmd.fill;

   always_comb begin
      base_in        = base_ff;
      first_block_in = first_block_ff;
      if (cmd.advance) begin
         base_in        = base_ff + AdvanceBy;
         first_block_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff        <= 8'd0;
         first_block_ff <= 1'b1;
      end else begin
         base_ff        <= base_in;
         first_block_ff <= first_block_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.smp_we) begin
         smp_mem[wr_addr] <= req_sample;
      end
      smp_rd_ff <= smp_mem[rd_addr];
      re_rd_ff  <= spec_re_mem[cmd.addr];
      im_rd_ff  <= spec_im_mem[cmd.addr];
      if (done_ff && !inv_s3_ff) begin
         spec_re_mem[cmd.wr_k] <= fr_sat;
         spec_im_mem[cmd.wr_k] <= fi_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
      end else begin
         valid_s1_ff <= cmd.issue;
      end
      first_s1_ff <= cmd.first;
      last_s1_ff  <= cmd.last;
      inv_s1_ff   <= cmd.inv;
      twid_s1_ff  <= cmd.twid;
      zero_s1_ff  <= first_block_ff && !cmd.inv && (cmd.addr < KeepLen);
   end

   always_comb begin
      cos_v = cos_lookup(twid_s1_ff);
      sin_v = sin_lookup(twid_s1_ff);
      if (inv_s1_ff) begin
         op_c = re_rd_ff;
         op_s = im_rd_ff;
      end else if (zero_s1_ff) begin
         op_c = '0;
         op_s = '0;
      end else begin
         op_c = SpecWidth'(smp_rd_ff);
         op_s = SpecWidth'(smp_rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s2_ff <= 1'b0;
      end else begin
         valid_s2_ff <= valid_s1_ff;
      end
      first_s2_ff <= first_s1_ff;
      last_s2_ff  <= last_s1_ff;
      inv_s2_ff   <= inv_s1_ff;
      pc_ff       <= op_c * cos_v;
      ps_ff       <= op_s * sin_v;
   end

   always_comb begin
      pc_x     = AccWidth'(pc_ff);
      ps_x     = AccWidth'(ps_ff);
      acc_a_in = acc_a_ff;
      acc_b_in = acc_b_ff;
      if (valid_s2_ff) begin
         acc_a_in = (first_s2_ff ? '0 : acc_a_ff) + (inv_s2_ff ? pc_x - ps_x : pc_x);
         acc_b_in = (first_s2_ff ? '0 : acc_b_ff) - ps_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= valid_s2_ff && last_s2_ff;
      end
      inv_s3_ff <= inv_s2_ff;
      acc_a_ff  <= acc_a_in;
      acc_b_ff  <= acc_b_in;
   end

   always_comb begin
      fr_s = (acc_a_ff + RndFwd) >>> 15;
      fi_s = (acc_b_ff + RndFwd) >>> 15;
      if (fr_s > (SpecMax >>> 1)) begin
         fr_sat = SpecWidth'(SpecMax);
      end else if (fr_s < (SpecMin >>> 1)) begin
         fr_sat = SpecWidth'(SpecMin);
      end else begin
         fr_sat = {fr_s[SpecWidth-2:0], 1'b0};
      end
      if (fi_s > (SpecMax >>> 1)) begin
         fi_sat = SpecWidth'(SpecMax);
      end else if (fi_s < (SpecMin >>> 1)) begin
         fi_sat = SpecWidth'(SpecMin);
      end else begin
         fi_sat = {fi_s[SpecWidth-2:0], 1'b0};
      end
      inv_v = acc_a_ff;
      if (inv_v > AccLim) begin
         inv_v = AccLim;
      end else if (inv_v < -AccLim) begin
         inv_v = -AccLim;
      end
      inv_w = (inv_v + RndInv) >>> 23;
      if (inv_w > OutMax) begin
         out_sat = OutWidth'(OutMax);
      end else if (inv_w < OutMin) begin
         out_sat = OutWidth'(OutMin);
      end else begin
         out_sat = inv_w[OutWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (done_ff && inv_s3_ff) begin
         slot_ff[cmd.wr_k[2:0]] <= out_sat;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_rsp) begin
         rsp_ff      <= slot_ff;
         rsp_last_ff <= cmd.rsp_last;
      end
   end

   assign status.done     = done_ff;
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_a         = rsp_ff[0];
   assign rsp_out_b         = rsp_ff[1];
   assign rsp_out_c         = rsp_ff[2];
   assign rsp_out_d         = rsp_ff[3];
   assign rsp_out_e         = rsp_ff[4];
   assign rsp_out_f         = rsp_ff[5];
   assign rsp_out_g         = rsp_ff[6];
   assign rsp_out_h         = rsp_ff[7];
   assign rsp_last_of_block = rsp_last_ff;

endmodule
`default_nettype wire

### rtl/fosu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fosu_ctrl: sequencing state machine
// Collects a window, walks the forward bins and the inverse outputs term by
// term, and hands each group of eight samples to the output register.
// ----------------------------------------------------------------------------
module fosu_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output fosu_pkg::cmd_type         cmd,
   input  wire fosu_pkg::status_type status
);
   import fosu_pkg::*;

   typedef enum logic [5:0] {
      COLLECT  = 6'b000001,
      FWD_RUN  = 6'b000010,
      FWD_WAIT = 6'b000100,
      INV_RUN  = 6'b001000,
      INV_WAIT = 6'b010000,
      EMIT     = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [7:0] k_ff, k_in;
   logic [7:0] n_ff, n_in;
   logic [8:0] m_ff, m_in;
   logic [8:0] phase_ff, phase_in;
   logic [7:0] fill_ff, fill_in;
   logic [8:0] jump;
   logic [7:0] k_step;

   assign jump   = {m_ff[0], 8'b0} + {m_ff[7:0], 1'b0};
   assign k_step = (k_ff == LowLast) ? HighFirst : k_ff + 8'd1;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      m_in     = m_ff;
      phase_in = phase_ff;
      fill_in  = fill_ff;
      cmd      = '0;
      cmd.fill = fill_ff;
      cmd.inv  = 1'b1;
      cmd.wr_k = {5'b0, m_ff[2:0]};
      case (state_ff)
         COLLECT: begin
            if (req_valid) begin
               cmd.smp_we = 1'b1;
               if (fill_ff == NewLast) begin
                  fill_in  = 8'd0;
                  k_in     = 8'd0;
                  n_in     = 8'd0;
                  phase_in = 9'd0;
                  state_in = FWD_RUN;
               end else begin
                  fill_in = fill_ff + 8'd1;
               end
            end
         end
         FWD_RUN: begin
            cmd.inv   = 1'b0;
            cmd.wr_k  = k_ff;
            cmd.issue = 1'b1;
            cmd.first = (n_ff == 8'd0);
            cmd.last  = (n_ff == BinLast);
            cmd.addr  = n_ff;
            cmd.twid  = {phase_ff[7:0], 1'b0};
            n_in      = n_ff + 8'd1;
            phase_in  = {1'b0, phase_ff[7:0] + k_ff};
            if (n_ff == BinLast) begin
               state_in = FWD_WAIT;
            end
         end
         FWD_WAIT: begin
            cmd.inv  = 1'b0;
            cmd.wr_k = k_ff;
            if (status.done) begin
               n_in     = 8'd0;
               phase_in = 9'd0;
               if (k_ff == BinLast) begin
                  k_in     = 8'd0;
                  m_in     = FirstOut;
                  state_in = INV_RUN;
               end else begin
                  k_in     = k_step;
                  state_in = FWD_RUN;
               end
            end
         end
         INV_RUN: begin
            cmd.issue = 1'b1;
            cmd.first = (k_ff == 8'd0);
            cmd.last  = (k_ff == BinLast);
            cmd.addr  = k_ff;
            cmd.twid  = phase_ff;
            k_in      = k_step;
            phase_in  = phase_ff + ((k_ff == LowLast) ? jump : m_ff);
            if (k_ff == BinLast) begin
               state_in = INV_WAIT;
            end
         end
         INV_WAIT: begin
            if (status.done) begin
               k_in     = 8'd0;
               phase_in = 9'd0;
               if (m_ff[2:0] == SlotLast) begin
                  state_in = EMIT;
               end else begin
                  m_in     = m_ff + 9'd1;
                  state_in = INV_RUN;
               end
            end
         end
         EMIT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_last = (m_ff == LastOut);
               if (m_ff == LastOut) begin
                  cmd.advance = 1'b1;
                  state_in    = COLLECT;
               end else begin
                  m_in     = m_ff + 9'd1;
                  state_in = INV_RUN;
               end
            end
         end
         default: begin
            state_in = COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= COLLECT;
         k_ff     <= 8'd0;
         n_ff     <= 8'd0;
         m_ff     <= FirstOut;
         phase_ff <= 9'd0;
         fill_ff  <= 8'd0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         n_ff     <= n_in;
         m_ff     <= m_in;
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
      end
   end

   assign req_stall = (state_ff != COLLECT);

`ifndef SYNTH
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (state_ff == FWD_WAIT || state_ff == INV_WAIT))
      else $error("transform result arrived outside a wait state");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.rsp_free)
      else $error("output register loaded while occupied");
   a_skip_nyquist: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FWD_RUN || state_ff == INV_RUN) |-> (k_ff != 8'd128))
      else $error("forward Nyquist bin was visited");
   a_advance_last: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |=> (state_ff == COLLECT && fill_ff == 8'd0))
      else $error("window advanced without returning to collection");
`endif

endmodule
`default_nettype wire

### rtl/fft_overlap_save_upsampler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fft_overlap_save_upsampler_top: 2x overlap-save spectral upsampler
// Input words are 16-bit samples on req_sample (req_valid / req_stall).
// Each 192 new samples, together with 64 kept from the previous window
// (zeros after reset), form a 256-point window. A forward transform and a
// zero-padded 512-point inverse transform follow, and the middle 384 real
// outputs leave as 48 words of eight 18-bit samples on rsp_* (rsp_valid /
// rsp_stall); rsp_last_of_block marks the 48th word.
// One shared multiply-accumulate pipeline computes every term of the 255
// forward bins and of the 384 inverse outputs. req_stall is high from the
// acceptance of the 192nd sample until the last word of the block is loaded
// into the output register. A stalled receiver holds the output word and
// pauses the inverse pass. Reset (synchronous) empties the window, drops
// any word held in the output register and makes the next window start
// with 64 zero samples.
// ----------------------------------------------------------------------------
module fft_overlap_save_upsampler_top (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic signed [15:0]  req_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [17:0]       rsp_out_a,
   output logic signed [17:0]       rsp_out_b,
   output logic signed [17:0]       rsp_out_c,
   output logic signed [17:0]       rsp_out_d,
   output logic signed [17:0]       rsp_out_e,
   output logic signed [17:0]       rsp_out_f,
   output logic signed [17:0]       rsp_out_g,
   output logic signed [17:0]       rsp_out_h,
   output logic                     rsp_last_of_block
);
   import fosu_pkg::*;

   cmd_type    cmd;
   status_type status;

   fosu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   fosu_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_sample        (req_sample),
      .cmd               (cmd),
      .status            (status),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_out_a         (rsp_out_a),
      .rsp_out_b         (rsp_out_b),
      .rsp_out_c         (rsp_out_c),
      .rsp_out_d         (rsp_out_d),
      .rsp_out_e         (rsp_out_e),
      .rsp_out_f         (rsp_out_f),
      .rsp_out_g         (rsp_out_g),
      .rsp_out_h         (rsp_out_h),
      .rsp_last_of_block (rsp_last_of_block)
   );

endmodule
`default_nettype wire

### tb/tb_fft_overlap_save_upsampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fft_overlap_save_upsampler_top: self-checking bench for the upsampler
// Drives one full block of samples: a directed table of extreme values and
// bit patterns, then random samples. The window opens with the 64 zero
// samples that follow reset. A predictor in the bench computes the
// fixed-point forward and inverse transforms, and every output word is
// compared field by field with the oldest expected word. The sender and the
// receiver idle at random, with the rates changing through each block.
// ----------------------------------------------------------------------------
module tb_fft_overlap_save_upsampler_top;
   import fosu_pkg::*;

   localparam int BlockNew   = 192;
   localparam int Blocks     = 1;
   localparam int WordsBlock = 48;

   typedef struct packed {
      logic [7:0][17:0] smp;
      logic             last;
   } word_type;

   typedef struct {
      logic signed [15:0] sample;
      bit                 quiet;
   } row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic signed [15:0]  req_sample = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [17:0]  rsp_out_a, rsp_out_b, rsp_out_c, rsp_out_d;
   logic signed [17:0]  rsp_out_e, rsp_out_f, rsp_out_g, rsp_out_h;
   logic                rsp_last_of_block;

   word_type expected_words[$];
   int       errors = 0;
   int       sent = 0;
   int       received = 0;

   int       qsine[0:128];
   int       window[0:255];
   int       fill_cnt;
   longint   spec_re[0:511];
   longint   spec_im[0:511];

   row_type  directed[24];

   always #5 clock = ~clock;

   fft_overlap_save_upsampler_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_a(rsp_out_a), .rsp_out_b(rsp_out_b), .rsp_out_c(rsp_out_c),
      .rsp_out_d(rsp_out_d), .rsp_out_e(rsp_out_e), .rsp_out_f(rsp_out_f),
      .rsp_out_g(rsp_out_g), .rsp_out_h(rsp_out_h),
      .rsp_last_of_block(rsp_last_of_block)
   );

   function automatic void make_sine_table();
      longint unsigned a, a2, term, pos, neg, val;
      for (int t = 0; t <= 128; t++) begin
         a = (longint'(t) * 64'd1686629713) / 128;
         a2 = (a * a) >> 30;
         term = a;
         pos = a;
         neg = 0;
         for (int n = 1; n <= 8; n++) begin
            term = ((term * a2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               neg += term;
            end else begin
               pos += term;
            end
         end
         val = (pos > neg) ? pos - neg : 0;
         val = (val + 16384) >> 15;
         if (val > 32767) begin
            val = 32767;
         end
         qsine[t] = int'(val);
      end
   endfunction

   function automatic longint twiddle_sin(int i);
      int p;
      int r;
      p = i % 512;
      r = p % 128;
      case (p / 128)
         0: begin return qsine[r]; end
         1: begin return qsine[128 - r]; end
         2: begin return -qsine[r]; end
         default: begin return -qsine[128 - r]; end
      endcase
   endfunction

   function automatic longint clamp40(longint v);
      if (v > 64'sd549755813887) begin
         return 64'sd549755813887;
      end
      if (v < -64'sd549755813888) begin
         return -64'sd549755813888;
      end
      return v;
   endfunction

   // Takes one accepted sample; on a full window it queues the 48 words.
   function automatic int upsample_window(logic signed [15:0] s);
      longint   sr, si, acc, v;
      int       idx, bin;
      word_type w;
      if (fill_cnt >= BlockNew) begin
         fill_cnt = 0;
      end
      window[64 + fill_cnt] = s;
      fill_cnt++;
      if (fill_cnt < BlockNew) begin
         return 0;
      end
      for (int k = 0; k < 512; k++) begin
         spec_re[k] = 0;
         spec_im[k] = 0;
      end
      for (int k = 0; k < 256; k++) begin
         if (k != 128) begin
            sr = 0;
            si = 0;
            for (int n = 0; n < 256; n++) begin
               idx = ((n * k) % 256) * 2;
               sr += window[n] * twiddle_sin(idx + 128);
               si -= window[n] * twiddle_sin(idx);
            end
            bin = (k < 128) ? k : k + 256;
            spec_re[bin] = clamp40(((sr + 16384) >>> 15) * 2);
            spec_im[bin] = clamp40(((si + 16384) >>> 15) * 2);
         end
      end
      for (int r = 0; r < WordsBlock; r++) begin
         for (int j = 0; j < 8; j++) begin
            acc = 0;
            for (int k = 0; k < 512; k++) begin
               idx = (k * (64 + r * 8 + j)) % 512;
               acc += spec_re[k] * twiddle_sin(idx + 128);
               acc -= spec_im[k] * twiddle_sin(idx);
            end
            v = acc;
            if (v > 64'sd4611686018427387904) begin
               v = 64'sd4611686018427387904;
            end
            if (v < -64'sd4611686018427387904) begin
               v = -64'sd4611686018427387904;
            end
            v = (v + 64'sd4194304) >>> 23;
            if (v > 131071) begin
               v = 131071;
            end
            if (v < -131072) begin
               v = -131072;
            end
            w.smp[j] = v[17:0];
         end
         w.last = (r == WordsBlock - 1);
         expected_words.push_back(w);
      end
      for (int n = 0; n < 64; n++) begin
         window[n] = window[192 + n];
      end
      fill_cnt = 0;
      return WordsBlock;
   endfunction

   function automatic bit roll(int pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   task automatic send_sample(logic signed [15:0] s, output int produced);
      int pct;
      pct = ((sent % BlockNew) / 64 == 0) ? 23 : ((sent % BlockNew) / 64 == 1) ? 56 : 0;
      @(negedge clock);
      while (roll(pct)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      do begin
         @(posedge clock);
      end while (req_stall);
      produced = upsample_window(s);
      sent++;
   endtask

   always @(negedge clock) begin
      int pct;
      pct = ((received % WordsBlock) / 16 == 0) ? 56
          : ((received % WordsBlock) / 16 == 1) ? 23 : 0;
      rsp_stall <= reset ? 1'b0 : roll(pct);
   end

   always @(posedge clock) begin
      word_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.smp = {rsp_out_h, rsp_out_g, rsp_out_f, rsp_out_e,
                    rsp_out_d, rsp_out_c, rsp_out_b, rsp_out_a};
         got.last = rsp_last_of_block;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, actual %h", $time, got);
            errors++;
         end else begin
            want = expected_words.pop_front();
            for (int j = 0; j < 8; j++) begin
               if (got.smp[j] !== want.smp[j]) begin
                  $display("%0t: word %0d sample %0d expected %0d actual %0d", $time,
                           received, j, $signed(want.smp[j]), $signed(got.smp[j]));
                  errors++;
               end
            end
            if (got.last !== want.last) begin
               $display("%0t: word %0d last_of_block expected %0b actual %0b",
                        $time, received, want.last, got.last);
               errors++;
            end
         end
         received++;
      end
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int produced;
      logic signed [15:0] s;
      // Extremes, single-bit patterns and sign flips; a partial window gives nothing.
      directed = '{
         '{16'sh7fff, 1}, '{16'sh8000, 1}, '{16'sh0000, 1}, '{16'sh0001, 1},
         '{16'shffff, 1}, '{16'sh5555, 1}, '{16'shaaaa, 1}, '{16'sh7fff, 1},
         '{16'sh8000, 1}, '{16'sh7fff, 1}, '{16'sh8000, 1}, '{16'sh4000, 1},
         '{16'shc000, 1}, '{16'sh00ff, 1}, '{16'shff00, 1}, '{16'sh0f0f, 1},
         '{16'shf0f0, 1}, '{16'sh7fff, 1}, '{16'sh7fff, 1}, '{16'sh7fff, 1},
         '{16'sh8000, 1}, '{16'sh8000, 1}, '{16'sh8000, 1}, '{16'sh0000, 1}};
      make_sine_table();
      for (int n = 0; n < 256; n++) begin
         window[n] = 0;
      end
      fill_cnt = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         send_sample(directed[i].sample, produced);
         if (directed[i].quiet && produced != 0) begin
            $display("%0t: row %0d expected no words, predictor gave %0d",
                     $time, i, produced);
            errors++;
         end
      end
      while (sent < Blocks * BlockNew) begin
         case ($urandom_range(3, 0))
            0: s = $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
            1: s = (sent % 2) ? 16'sh7fff : 16'sh8000;
            default: s = 16'($urandom);
         endcase
         send_sample(s, produced);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_words.size() == 0);
      repeat (200) @(posedge clock);
      $display("Sent %0d samples over %0d full windows, checked %0d output words.",
               sent, Blocks, received);
      $display("Covered full-scale extremes, alternating signs and random samples.");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/fosu_pkg.sv
rtl/fosu_datapath.sv
rtl/fosu_ctrl.sv
rtl/fft_overlap_save_upsampler_top.sv
tb/tb_fft_overlap_save_upsampler_top.sv
